@@ rtl/lscp_pkg.sv @@
// package: sizes, register indexes and controller/datapath command and status types
package lscp_pkg;

  localparam int SENSOR_COUNT  = 5;
  localparam int SAMPLE_BITS   = 10;
  localparam int POS_FRAC_BITS = 14;

  localparam int RECT_W = 10;
  localparam int POS_W  = 16;
  localparam int IDX_W  = $clog2(SENSOR_COUNT);

  // sum of rectified values and the weighted sum
  localparam int SUM_W = $clog2(SENSOR_COUNT * ((1 << RECT_W) - 1) + 1);
  localparam int DEN_W = $clog2((SENSOR_COUNT - 1) * SENSOR_COUNT * ((1 << RECT_W) - 1) + 1);

  // shared divider sizing
  localparam int PROD_W    = SAMPLE_BITS + RECT_W;
  localparam int POS_DVD_W = DEN_W + POS_FRAC_BITS;
  localparam int DVD_W     = (PROD_W > POS_DVD_W) ? PROD_W : POS_DVD_W;
  localparam int DSR_W     = (DEN_W > SAMPLE_BITS) ? DEN_W : SAMPLE_BITS;
  localparam int CNT_W     = $clog2(DVD_W + 1);

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = RECT_W;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HIGH = CFG_IDX_W'(1);
  localparam logic [RECT_W-1:0]    RECT_LOW_RST  = RECT_W'(0);
  localparam logic [RECT_W-1:0]    RECT_HIGH_RST = RECT_W'(1000);

  typedef struct packed {
    logic             capture;
    logic             cal_wr;
    logic             rect_direct_wr;
    logic             div_start_rect;
    logic             rect_div_wr;
    logic             pos_zero_wr;
    logic             div_start_pos;
    logic             pos_div_wr;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic div_done;
    logic sum_zero;
    logic out_free;
  } status_t;

endpackage

@@ rtl/lscp_if.sv @@
// item channel interfaces: sensor frames in, calibrated results out
interface lscp_in_if import lscp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [SAMPLE_BITS-1:0] raw_0;
  logic [SAMPLE_BITS-1:0] raw_1;
  logic [SAMPLE_BITS-1:0] raw_2;
  logic [SAMPLE_BITS-1:0] raw_3;
  logic [SAMPLE_BITS-1:0] raw_4;

  modport source (output valid, req_type, raw_0, raw_1, raw_2, raw_3, raw_4, input ready);
  modport sink   (input valid, req_type, raw_0, raw_1, raw_2, raw_3, raw_4, output ready);
endinterface

interface lscp_out_if import lscp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [RECT_W-1:0]       rect_0;
  logic [RECT_W-1:0]       rect_1;
  logic [RECT_W-1:0]       rect_2;
  logic [RECT_W-1:0]       rect_3;
  logic [RECT_W-1:0]       rect_4;
  logic signed [POS_W-1:0] line_position;
  logic                    line_seen;

  modport source (output valid, rect_0, rect_1, rect_2, rect_3, rect_4, line_position,
                  line_seen, input ready);
  modport sink   (input valid, rect_0, rect_1, rect_2, rect_3, rect_4, line_position,
                  line_seen, output ready);
endinterface

@@ rtl/lscp_div.sv @@
// iterative restoring divider, one quotient bit per cycle, dividend left-aligned
module lscp_div import lscp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = count_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      rem_d = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/lscp_ctrl.sv @@
// sequencer: walks the sensors one at a time, then the position division unless the sum is zero
module lscp_ctrl import lscp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CAL  = 7'b0000010,
    S_PREP = 7'b0000100,
    S_DIVR = 7'b0001000,
    S_POSP = 7'b0010000,
    S_DIVP = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last;

  assign last       = idx_q == IDX_W'(SENSOR_COUNT - 1);
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_o     = '0;
    cmd_o.idx = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          idx_d         = '0;
          state_d       = S_CAL;
        end
      end
      S_CAL: begin
        cmd_o.cal_wr = 1'b1;
        state_d      = S_PREP;
      end
      S_PREP: begin
        if (status_i.need_div) begin
          cmd_o.div_start_rect = 1'b1;
          state_d              = S_DIVR;
        end else begin
          cmd_o.rect_direct_wr = 1'b1;
          if (last) begin
            state_d = S_POSP;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_CAL;
          end
        end
      end
      S_DIVR: begin
        if (status_i.div_done) begin
          cmd_o.rect_div_wr = 1'b1;
          if (last) begin
            state_d = S_POSP;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_CAL;
          end
        end
      end
      S_POSP: begin
        if (status_i.sum_zero) begin
          cmd_o.pos_zero_wr = 1'b1;
          state_d           = S_DONE;
        end else begin
          cmd_o.div_start_pos = 1'b1;
          state_d             = S_DIVP;
        end
      end
      S_DIVP: begin
        if (status_i.div_done) begin
          cmd_o.pos_div_wr = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

@@ rtl/lscp_datapath.sv @@
// datapath: calibration ranges, rectify, centroid accumulate, output register
module lscp_datapath import lscp_pkg::*; (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  cmd_t                                     cmd_i,
  output status_t                                  status_o,
  input  logic                                     req_type_i,
  input  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] raw_i,
  input  logic                                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                    cfg_data_i,
  input  logic                                     out_ready_i,
  output logic                                     out_valid_o,
  output logic [SENSOR_COUNT-1:0][RECT_W-1:0]      out_rect_o,
  output logic signed [POS_W-1:0]                  out_pos_o,
  output logic                                     out_seen_o
);

  localparam logic signed [DVD_W:0] SAT_HI = (DVD_W + 1)'((2 ** (POS_W - 1)) - 1);
  localparam logic signed [DVD_W:0] SAT_LO = -SAT_HI - (DVD_W + 1)'(1);

  logic                                     learn_q;
  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] raw_q;
  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] cal_low_q;
  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] cal_high_q;
  logic [RECT_W-1:0]                        rect_low_q;
  logic [RECT_W-1:0]                        rect_high_q;
  logic [SENSOR_COUNT-1:0][RECT_W-1:0]      rect_q;
  logic [SUM_W-1:0]                         sum_q;
  logic [DEN_W-1:0]                         num_q;
  logic                                     pos_neg_q;
  logic [POS_W-1:0]                         pos_q;
  logic                                     out_valid_q;
  logic [SENSOR_COUNT-1:0][RECT_W-1:0]      out_rect_q;
  logic [POS_W-1:0]                         out_pos_q;
  logic                                     out_seen_q;

  logic [SAMPLE_BITS-1:0] raw_s, lo_s, hi_s, diff_s;
  logic [RECT_W-1:0]      span_s, rect_direct_s, rect_div_s, rect_new_s;
  logic                   empty_s;
  logic [PROD_W-1:0]      prod_s;
  logic [DEN_W-1:0]       denom_s;
  logic signed [DEN_W+1:0] numer_s, mag_full_s;
  logic                   neg_s;
  logic [DVD_W-1:0]       div_dvd_s;
  logic [DSR_W-1:0]       div_dsr_s;
  logic [CNT_W-1:0]       div_cnt_s;
  logic                   div_start_s;
  logic                   div_busy_s, div_done_s;
  logic [DVD_W-1:0]       quo_s;
  logic signed [DVD_W:0]  pos_val_s;
  logic [POS_W-1:0]       pos_sat_s;

  // per-sensor rectify
  assign raw_s  = raw_q[cmd_i.idx];
  assign lo_s   = cal_low_q[cmd_i.idx];
  assign hi_s   = cal_high_q[cmd_i.idx];
  assign diff_s = raw_s - lo_s;
  assign span_s = (rect_high_q > rect_low_q) ? (rect_high_q - rect_low_q) : '0;

  assign empty_s       = (hi_s <= lo_s) || (raw_s <= lo_s);
  assign rect_direct_s = empty_s ? rect_low_q : (rect_low_q + span_s);
  assign prod_s        = PROD_W'(diff_s) * PROD_W'(span_s);
  // quotient stays below span, so the low bits hold it
  assign rect_div_s    = rect_low_q + quo_s[RECT_W-1:0];
  assign rect_new_s    = cmd_i.rect_div_wr ? rect_div_s : rect_direct_s;

  // centroid: numer = 2*num - (n-1)*sum over denom = (n-1)*sum
  assign denom_s    = DEN_W'(sum_q) * DEN_W'(SENSOR_COUNT - 1);
  assign numer_s    = $signed({1'b0, num_q, 1'b0}) - $signed({2'b00, denom_s});
  assign neg_s      = numer_s[DEN_W+1];
  assign mag_full_s = neg_s ? -numer_s : numer_s;

  always_comb begin
    if (cmd_i.div_start_pos) begin
      div_dvd_s = DVD_W'(mag_full_s[DEN_W-1:0]) << (DVD_W - DEN_W);
      div_dsr_s = DSR_W'(denom_s);
      div_cnt_s = CNT_W'(POS_DVD_W);
    end else begin
      div_dvd_s = DVD_W'(prod_s) << (DVD_W - PROD_W);
      div_dsr_s = DSR_W'(diff_s + (hi_s - raw_s));
      div_cnt_s = CNT_W'(PROD_W);
    end
  end
  assign div_start_s = cmd_i.div_start_rect | cmd_i.div_start_pos;

  lscp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_s),
    .dividend_i (div_dvd_s),
    .divisor_i  (div_dsr_s),
    .count_i    (div_cnt_s),
    .busy_o     (div_busy_s),
    .done_o     (div_done_s),
    .quotient_o (quo_s)
  );

  // truncation toward zero, then saturate to the output width
  assign pos_val_s = pos_neg_q ? -$signed({1'b0, quo_s}) : $signed({1'b0, quo_s});
  always_comb begin
    if (pos_val_s > SAT_HI) begin
      pos_sat_s = SAT_HI[POS_W-1:0];
    end else if (pos_val_s < SAT_LO) begin
      pos_sat_s = SAT_LO[POS_W-1:0];
    end else begin
      pos_sat_s = pos_val_s[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_low_q  <= RECT_LOW_RST;
      rect_high_q <= RECT_HIGH_RST;
      cal_low_q   <= {SENSOR_COUNT{{SAMPLE_BITS{1'b1}}}};
      cal_high_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_RECT_LOW) begin
          rect_low_q <= cfg_data_i;
        end else if (cfg_idx_i == REG_RECT_HIGH) begin
          rect_high_q <= cfg_data_i;
        end
      end
      if (cmd_i.cal_wr && learn_q) begin
        cal_low_q[cmd_i.idx]  <= (raw_s < lo_s) ? raw_s : lo_s;
        cal_high_q[cmd_i.idx] <= (raw_s > hi_s) ? raw_s : hi_s;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      learn_q <= req_type_i;
      raw_q   <= raw_i;
      sum_q   <= '0;
      num_q   <= '0;
    end
    if (cmd_i.rect_direct_wr || cmd_i.rect_div_wr) begin
      rect_q[cmd_i.idx] <= rect_new_s;
      sum_q             <= sum_q + SUM_W'(rect_new_s);
      num_q             <= num_q + DEN_W'(cmd_i.idx) * DEN_W'(rect_new_s);
    end
    if (cmd_i.div_start_pos) begin
      pos_neg_q <= neg_s;
    end
    if (cmd_i.pos_zero_wr) begin
      pos_q <= '0;
    end else if (cmd_i.pos_div_wr) begin
      pos_q <= pos_sat_s;
    end
    if (cmd_i.out_load) begin
      out_rect_q <= rect_q;
      out_pos_q  <= pos_q;
      out_seen_q <= sum_q != '0;
    end
  end

  assign status_o.need_div = !empty_s && (raw_s < hi_s);
  assign status_o.div_busy = div_busy_s;
  assign status_o.div_done = div_done_s;
  assign status_o.sum_zero = sum_q == '0;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rect_o  = out_rect_q;
  assign out_pos_o   = $signed(out_pos_q);
  assign out_seen_o  = out_seen_q;

endmodule

@@ rtl/line_sensor_calibrate_position_unit.sv @@
// Line sensor calibration and centroid position unit.
// Input channel in_if carries one frame: req_type (1 = widen the per-sensor
// min/max range from this frame first) and five 10-bit raw samples. Output
// channel out_if returns five rectified values, the line position in signed
// Q2.14 and a line-seen flag, one result item per frame.
// rect_low / rect_high are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write them only while the unit is idle, which the unit
// itself does not enforce. Other indexes are ignored.
// Sensors are handled one after another; a sensor that falls inside its range
// needs a 20-step pass of the shared bit-serial divider. The position then
// needs a 29-step division when the sum is nonzero and is zero otherwise;
// then the output register is loaded and the unit returns to idle.
// in_if.ready is high only while no frame is in work. A finished result sits
// in the output register; a new frame is still accepted while it waits, and
// that frame stalls before its own load until the receiver takes the first.
// Reset sets rect_low 0, rect_high 1000, every calibration low end 1023 and
// high end 0, and empties the output register.
module line_sensor_calibrate_position_unit import lscp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lscp_in_if.sink               in_if,
  lscp_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t                                     cmd;
  status_t                                  status;
  logic                                     in_ready;
  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] raw;
  logic [SENSOR_COUNT-1:0][RECT_W-1:0]      rect;
  logic signed [POS_W-1:0]                  pos;
  logic                                     seen;
  logic                                     out_valid;

  assign raw = {in_if.raw_4, in_if.raw_3, in_if.raw_2, in_if.raw_1, in_if.raw_0};

  lscp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lscp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_type_i  (in_if.req_type),
    .raw_i       (raw),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_valid),
    .out_rect_o  (rect),
    .out_pos_o   (pos),
    .out_seen_o  (seen)
  );

  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid;
  assign out_if.rect_0        = rect[0];
  assign out_if.rect_1        = rect[1];
  assign out_if.rect_2        = rect[2];
  assign out_if.rect_3        = rect[3];
  assign out_if.rect_4        = rect[4];
  assign out_if.line_position = pos;
  assign out_if.line_seen     = seen;

  // an accepted frame takes the unit out of its ready state
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("unit still ready after taking a frame");

  // no line means the position reads zero
  a_unseen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.line_seen |-> out_if.line_position == '0)
    else $error("nonzero position with no line seen");

  // the shared divider is never restarted in the middle of a division
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start_rect || cmd.div_start_pos |-> !status.div_busy)
    else $error("divider started while busy");

endmodule
